>>> rtl/grs_pkg.sv
// ----------------------------------------------------------------------------
// grs_pkg: shared types and constants for the reaction selector
// Op and status codes, controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package grs_pkg;

  localparam logic [1:0] OP_SUBMIT = 2'd0;
  localparam logic [1:0] OP_SELECT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // ln(2) as Q0.32
  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

  localparam logic [5:0] SQ_STEPS  = 6'd32;
  localparam logic [5:0] DIV_STEPS = 6'd56;

  typedef struct packed {
    logic load;
    logic dispatch;
    logic tgt_mul;
    logic tgt_add;
    logic walk_step;
    logic norm_step;
    logic sq_step;
    logic ln_mul;
    logic ln_add;
    logic div_init;
    logic div_step;
    logic res_load;
  } grs_cmd_t;

  typedef struct packed {
    logic sel_go;
    logic walk_done;
    logic norm_done;
    logic sq_done;
    logic div_done;
  } grs_stat_t;

endpackage

`default_nettype wire

>>> rtl/grs_in_if.sv
// ----------------------------------------------------------------------------
// grs_in_if: input channel of the reaction selector
// Valid/ready handshake carrying one op item.
// ----------------------------------------------------------------------------
`default_nettype none

interface grs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] reaction_tag;
  logic [31:0] propensity;
  logic [31:0] rand_time;
  logic [31:0] rand_pick;

  modport source (output valid, op, reaction_tag, propensity, rand_time, rand_pick,
                  input ready);
  modport sink   (input valid, op, reaction_tag, propensity, rand_time, rand_pick,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/grs_out_if.sv
// ----------------------------------------------------------------------------
// grs_out_if: result channel of the reaction selector
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface grs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] chosen_tag;
  logic [55:0] wait_time;
  logic [8:0]  live_count;

  modport source (output valid, status, chosen_tag, wait_time, live_count,
                  input ready);
  modport sink   (input valid, status, chosen_tag, wait_time, live_count,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/grs_datapath.sv
// ----------------------------------------------------------------------------
// grs_datapath: reaction table and select arithmetic
// Table memories, running total, target multiply, newest-first walk,
// normalize / squaring log2, ln scaling and a restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module grs_datapath #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  grs_pkg::grs_cmd_t   cmd,
  output grs_pkg::grs_stat_t  stat,
  input  logic [1:0]          in_op,
  input  logic [15:0]         in_tag,
  input  logic [31:0]         in_prop,
  input  logic [31:0]         in_rtime,
  input  logic [31:0]         in_rpick,
  output logic [1:0]          res_status,
  output logic [15:0]         res_tag,
  output logic [55:0]         res_wait,
  output logic [8:0]          res_count
);
  import grs_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = (32 + CW > 41) ? 32 + CW : 41;

  // latched item
  logic [1:0]  op_r;
  logic [15:0] tag_r;
  logic [31:0] prop_r, rt_r, rp_r;

  // table state
  logic [31:0]   rate_mem [MAX_ENTRIES];
  logic [15:0]   tag_mem  [MAX_ENTRIES];
  logic [CW-1:0] count;
  logic [39:0]   total;

  logic [1:0]  disp_status, item_status;
  logic        sel_ok;

  logic [63:0]   prod_lo;
  logic [40:0]   target;
  logic [CW-1:0] idx, idx_m1;
  logic [AW-1:0] rd_addr;
  logic          rd_en, rd_vld, hit;
  logic [31:0]   rd_rate;
  logic [15:0]   rd_tag, tag_pick;
  logic [SW-1:0] sum, sum_n;

  logic [31:0] rn, frac;
  logic [4:0]  p;
  logic [5:0]  cnt;
  logic [63:0] sq;
  logic [32:0] sq_sh;
  logic [37:0] neg;
  logic [63:0] lnprod;
  logic [38:0] lnsum;
  logic [30:0] lnv;
  logic [40:0] rem, rem_sh;
  logic [55:0] quo;
  logic        ge;

  logic        full, sel_empty, mem_we;
  logic [40:0] tot_sum;

  assign full      = (count == CW'(MAX_ENTRIES));
  assign sel_empty = (count == '0) || (total == '0);
  assign mem_we    = cmd.dispatch && (op_r == OP_SUBMIT) && (prop_r != '0) && !full;
  assign tot_sum   = {1'b0, total} + {9'd0, prop_r};

  always_comb begin
    disp_status = ST_OK;
    unique case (op_r)
      OP_SUBMIT: begin
        if (prop_r == '0) disp_status = ST_ZERO;
        else if (full)    disp_status = ST_FULL;
      end
      OP_SELECT: begin
        if (sel_empty) disp_status = ST_EMPTY;
      end
      default: disp_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      tag_r  <= in_tag;
      prop_r <= in_prop;
      rt_r   <= in_rtime;
      rp_r   <= in_rpick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (cmd.dispatch) begin
      if (mem_we) begin
        count <= count + CW'(1);
        total <= tot_sum[40] ? '1 : tot_sum[39:0];
      end else if (op_r == OP_CLEAR) begin
        count <= '0;
        total <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rate_mem[count[AW-1:0]] <= prop_r;
      tag_mem[count[AW-1:0]]  <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dispatch) begin
      item_status <= disp_status;
      sel_ok      <= (op_r == OP_SELECT) && !sel_empty;
    end
  end

  // target = floor(r2 * total / 2^32)
  always_ff @(posedge clk) begin
    if (cmd.tgt_mul) prod_lo <= 64'(rp_r) * 64'(total[31:0]);
    if (cmd.tgt_add) target  <= 41'(64'(rp_r) * 64'(total[39:32])) + {9'd0, prod_lo[63:32]};
  end

  // walk: one read issued per cycle, compared in the following cycle
  assign idx_m1  = idx - CW'(1);
  assign rd_addr = idx_m1[AW-1:0];
  assign rd_en   = cmd.walk_step && (idx != '0) && !hit;
  assign sum_n   = sum + SW'(rd_rate);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rate <= rate_mem[rd_addr];
      rd_tag  <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit    <= 1'b0;
      rd_vld <= 1'b0;
      sum    <= '0;
    end else if (cmd.tgt_mul) begin
      hit    <= 1'b0;
      rd_vld <= 1'b0;
      sum    <= '0;
    end else if (cmd.walk_step) begin
      rd_vld <= rd_en;
      if (rd_vld && !hit) begin
        sum      <= sum_n;
        tag_pick <= rd_tag;
        if (sum_n >= SW'(target)) hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tgt_mul)   idx <= count;
    else if (rd_en)    idx <= idx_m1;
  end

  // log2 by normalize then repeated squaring
  assign sq    = 64'(rn) * 64'(rn);
  assign sq_sh = sq[63:31];
  assign neg   = {6'd32 - {1'b0, p}, 32'd0} - {6'd0, frac};
  assign lnsum = 39'(neg[37:32]) * 39'(LN2_Q32) + {7'd0, lnprod[63:32]} + 39'd128;

  always_ff @(posedge clk) begin
    if (cmd.tgt_mul) begin
      rn  <= (rt_r == '0) ? 32'd1 : rt_r;
      p   <= 5'd31;
      cnt <= '0;
    end else if (cmd.norm_step) begin
      rn <= {rn[30:0], 1'b0};
      p  <= p - 5'd1;
    end else if (cmd.sq_step) begin
      rn   <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
      frac <= {frac[30:0], sq_sh[32]};
      cnt  <= cnt + 6'd1;
    end else if (cmd.div_init) begin
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ln_mul) lnprod <= 64'(neg[31:0]) * 64'(LN2_Q32);
    if (cmd.ln_add) lnv    <= lnsum[38:8];
  end

  // restoring divide, one quotient bit per cycle
  assign rem_sh = {rem[39:0], quo[55]};
  assign ge     = (rem_sh >= {1'b0, total});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= '0;
      quo <= {1'b0, lnv, 24'd0};
    end else if (cmd.div_step) begin
      rem <= ge ? rem_sh - {1'b0, total} : rem_sh;
      quo <= {quo[54:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= item_status;
      res_tag    <= sel_ok ? tag_pick : 16'd0;
      res_wait   <= sel_ok ? quo : 56'd0;
      res_count  <= 9'(count);
    end
  end

  assign stat.sel_go    = (op_r == OP_SELECT) && !sel_empty;
  assign stat.walk_done = hit || ((idx == '0) && !rd_vld);
  assign stat.norm_done = rn[31];
  assign stat.sq_done   = (cnt == SQ_STEPS);
  assign stat.div_done  = (cnt == DIV_STEPS);

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_hit_sum: assert property (@(posedge clk) disable iff (rst)
    hit |-> (sum >= SW'(target)))
    else $error("walk hit without sum reaching target");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    (mem_we && !tot_sum[40]) |=> (total == $past(tot_sum[39:0])))
    else $error("running total not updated on submit");

endmodule

`default_nettype wire

>>> rtl/grs_ctrl.sv
// ----------------------------------------------------------------------------
// grs_ctrl: sequencer for the reaction selector
// One-hot state machine issuing datapath commands; owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module grs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output grs_pkg::grs_cmd_t   cmd,
  input  grs_pkg::grs_stat_t  stat
);
  import grs_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_DISP = 12'b0000_0000_0010,
    S_TGT1 = 12'b0000_0000_0100,
    S_TGT2 = 12'b0000_0000_1000,
    S_WALK = 12'b0000_0001_0000,
    S_NORM = 12'b0000_0010_0000,
    S_SQR  = 12'b0000_0100_0000,
    S_LN1  = 12'b0000_1000_0000,
    S_LN2  = 12'b0001_0000_0000,
    S_DIVI = 12'b0010_0000_0000,
    S_DIV  = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;
  logic   in_fire, out_free;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        cmd.dispatch = 1'b1;
        state_next   = stat.sel_go ? S_TGT1 : S_FIN;
      end
      S_TGT1: begin
        cmd.tgt_mul = 1'b1;
        state_next  = S_TGT2;
      end
      S_TGT2: begin
        cmd.tgt_add = 1'b1;
        state_next  = S_WALK;
      end
      S_WALK: begin
        if (stat.walk_done) state_next = S_NORM;
        else cmd.walk_step = 1'b1;
      end
      S_NORM: begin
        if (stat.norm_done) state_next = S_SQR;
        else cmd.norm_step = 1'b1;
      end
      S_SQR: begin
        if (stat.sq_done) state_next = S_LN1;
        else cmd.sq_step = 1'b1;
      end
      S_LN1: begin
        cmd.ln_mul = 1'b1;
        state_next = S_LN2;
      end
      S_LN2: begin
        cmd.ln_add = 1'b1;
        state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_FIN;
        else cmd.div_step = 1'b1;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_fire_disp: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == S_DISP))
    else $error("accepted item not dispatched");

  a_fin_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished item not presented");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command");

endmodule

`default_nettype wire

>>> rtl/gillespie_reaction_selector_core.sv
// ----------------------------------------------------------------------------
// gillespie_reaction_selector_core: direct-method reaction table engine
// Submit, select (tag pick plus waiting time) and clear on one item channel.
// ----------------------------------------------------------------------------
// Submit, clear and unused ops: accept, dispatch, then the result once the output is free.
// Select: accept, dispatch, target multiply, then a walk over the entries (one per cycle
//   from the table read port), normalize of r1 to its leading one, 32 squaring steps,
//   ln scaling and a 56-step divide; the result is loaded once the output is free.
// One item in flight; a new item is taken while the previous result waits.
// Reset (rst, synchronous) empties the table; table memories are not cleared.
`default_nettype none

module gillespie_reaction_selector_core #(
  parameter int MAX_ENTRIES = 256
) (
  input logic      clk,
  input logic      rst,
  grs_in_if.sink   in_ch,
  grs_out_if.source out_ch
);
  import grs_pkg::*;

  grs_cmd_t  cmd;
  grs_stat_t stat;

  grs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  grs_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_ch.op),
    .in_tag     (in_ch.reaction_tag),
    .in_prop    (in_ch.propensity),
    .in_rtime   (in_ch.rand_time),
    .in_rpick   (in_ch.rand_pick),
    .res_status (out_ch.status),
    .res_tag    (out_ch.chosen_tag),
    .res_wait   (out_ch.wait_time),
    .res_count  (out_ch.live_count)
  );

endmodule

`default_nettype wire

>>> verif/grs_selector_scoreboard.sv
// ----------------------------------------------------------------------------
// grs_selector_scoreboard: expected-result tracker for the reaction selector
// Mirrors the reaction table, computes the result of each accepted item and
// compares it with the block's results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class grs_selector_scoreboard;
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] chosen_tag;
    logic [55:0] wait_time;
    logic [8:0]  live_count;
  } grs_result_t;

  int unsigned  table_depth;
  logic [31:0]  rates[$];
  logic [15:0]  tags[$];
  logic [39:0]  rate_sum;
  grs_result_t  pending[$];
  int unsigned  mismatches;

  function new(int unsigned depth);
    table_depth = depth;
    rate_sum = '0;
    mismatches = 0;
  endfunction

  // -ln(r / 2^32), r != 0, rounded to Q8.24
  function automatic logic [63:0] neg_ln_q24(logic [31:0] r);
    int p;
    logic [63:0] m, frac, neg, prod;
    p = 31;
    frac = '0;
    while (r[p] == 1'b0) p--;
    m = 64'(r) << (31 - p);
    for (int i = 31; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac[i] = 1'b1;
      end
    end
    neg = (64'(32 - p) << 32) - frac;
    prod = neg[63:32] * 64'(grs_pkg::LN2_Q32)
         + ((64'(neg[31:0]) * 64'(grs_pkg::LN2_Q32)) >> 32);
    return (prod + 64'd128) >> 8;
  endfunction

  function void note_item(logic [1:0] op, logic [15:0] tag, logic [31:0] prop,
                          logic [31:0] r1, logic [31:0] r2);
    grs_result_t res;
    logic [63:0] target, acc, lnv;
    logic [127:0] quo;
    logic [40:0] grown;
    int pick;
    res = '0;
    case (op)
      grs_pkg::OP_SUBMIT: begin
        if (prop == 0) res.status = grs_pkg::ST_ZERO;
        else if (rates.size() >= table_depth) res.status = grs_pkg::ST_FULL;
        else begin
          rates.push_back(prop);
          tags.push_back(tag);
          grown = {1'b0, rate_sum} + 41'(prop);
          // total saturates at the top of its range
          rate_sum = grown[40] ? '1 : grown[39:0];
        end
      end
      grs_pkg::OP_SELECT: begin
        if (rates.size() == 0 || rate_sum == 0) res.status = grs_pkg::ST_EMPTY;
        else begin
          target = 64'(r2) * 64'(rate_sum[39:32])
                 + ((64'(r2) * 64'(rate_sum[31:0])) >> 32);
          acc = '0;
          pick = 0;
          for (int i = rates.size() - 1; i >= 0; i--) begin
            acc += 64'(rates[i]);
            if (acc >= target) begin
              pick = i;
              break;
            end
          end
          res.chosen_tag = tags[pick];
          lnv = neg_ln_q24(r1 == 0 ? 32'd1 : r1);
          quo = (128'(lnv) << 24) / 128'(rate_sum);
          res.wait_time = quo[55:0];
        end
      end
      grs_pkg::OP_CLEAR: begin
        rates.delete();
        tags.delete();
        rate_sum = '0;
      end
      default: ;
    endcase
    res.live_count = 9'(rates.size());
    pending.push_back(res);
  endfunction

  function void check_result(grs_result_t got);
    grs_result_t exp;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    exp = pending.pop_front();
    if (got.status !== exp.status || got.chosen_tag !== exp.chosen_tag ||
        got.wait_time !== exp.wait_time || got.live_count !== exp.live_count) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp st=%0d tag=%h wait=%h cnt=%0d, got st=%0d tag=%h wait=%h cnt=%0d",
                 exp.status, exp.chosen_tag, exp.wait_time, exp.live_count,
                 got.status, got.chosen_tag, got.wait_time, got.live_count);
    end
  endfunction
endclass

>>> verif/gillespie_reaction_selector_core_tb.sv
// ----------------------------------------------------------------------------
// gillespie_reaction_selector_core_tb: self-checking bench for the selector
// Directed corner items, then random submit/select/clear/unused traffic with random
// idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gillespie_reaction_selector_core_tb;
  import grs_pkg::*;

  localparam int DEPTH    = 256;
  localparam int WDOG_MAX = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  grs_in_if  in_ch ();
  grs_out_if out_ch ();

  gillespie_reaction_selector_core #(.MAX_ENTRIES(DEPTH)) u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  grs_selector_scoreboard sb;
  int  idle_pct = 6;
  bit  hold_off = 1'b0;
  int  quiet;
  bit  timed_out = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_SUBMIT;
    in_ch.reaction_tag = '0;
    in_ch.propensity = '0;
    in_ch.rand_time = '0;
    in_ch.rand_pick = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      sb.note_item(in_ch.op, in_ch.reaction_tag, in_ch.propensity,
                   in_ch.rand_time, in_ch.rand_pick);
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.status, out_ch.chosen_tag, out_ch.wait_time,
                       out_ch.live_count});
  end

  always @(posedge clk) begin
    if (!rst) out_ch.ready <= !hold_off && ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet <= 0;
    else begin
      quiet <= quiet + 1;
      if (quiet >= WDOG_MAX && !timed_out) begin
        timed_out = 1'b1;
        $display("gillespie_reaction_selector_core test failed");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [15:0] tag, logic [31:0] prop,
                           logic [31:0] r1, logic [31:0] r2);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.reaction_tag <= tag;
    in_ch.propensity <= prop;
    in_ch.rand_time <= r1;
    in_ch.rand_pick <= r2;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_rate();
    case ($urandom_range(3))
      0: return $urandom_range(255) + 1;
      1: return $urandom;
      2: return 32'hFFFF_FFFF - $urandom_range(15);
      default: return {16'd0, 16'($urandom)} + 32'd1;
    endcase
  endfunction

  function automatic logic [31:0] rnd_frac();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n;
    sb = new(DEPTH);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_item(OP_SELECT, 16'h1234, 32'd5, 32'd7, 32'd9);
    send_item(OP_SUBMIT, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_SUBMIT, 16'h0000, 32'd1, 32'd0, 32'd0);
    send_item(OP_SUBMIT, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_item(OP_SUBMIT, 16'hA5A5, 32'h0001_0000, 32'd0, 32'd0);
    send_item(OP_SELECT, 16'd0, 32'd0, 32'd0, 32'd0);
    send_item(OP_SELECT, 16'd0, 32'd0, 32'd1, 32'hFFFF_FFFF);
    send_item(OP_SELECT, 16'd0, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000);
    send_item(OP_SELECT, 16'd0, 32'd0, 32'h8000_0000, 32'h0000_0001);
    send_item(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_CLEAR, 16'd0, 32'd0, 32'd0, 32'd0);
    send_item(OP_SELECT, 16'd0, 32'd0, 32'd3, 32'd3);
    // fill the table past its limit
    for (int i = 0; i <= DEPTH; i++)
      send_item(OP_SUBMIT, 16'(i), rnd_rate(), $urandom, $urandom);
    send_item(OP_SELECT, 16'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(OP_SELECT, 16'd0, 32'd0, $urandom, 32'd0);
    send_item(OP_CLEAR, 16'd0, 32'd0, 32'd0, 32'd0);

    // long output stall with the sender still pushing
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_item(OP_SUBMIT, 16'($urandom), rnd_rate(), $urandom, $urandom);
    join

    // random traffic: submits, mostly selects, occasional clear and unused ops
    n = 0;
    while (n < 820) begin
      if (n >= 400 && n < 600) idle_pct = 0;
      else idle_pct = 6;
      case ($urandom_range(99)) inside
        [0:39]:  send_item(OP_SUBMIT, 16'($urandom),
                   ($urandom_range(19) == 0) ? 32'd0 : rnd_rate(), $urandom, $urandom);
        [40:94]: send_item(OP_SELECT, 16'($urandom), $urandom, rnd_frac(), rnd_frac());
        [95:97]: send_item(OP_CLEAR, 16'($urandom), $urandom, $urandom, $urandom);
        default: send_item(OP_UNUSED, 16'($urandom), $urandom, $urandom, $urandom);
      endcase
      n++;
    end
    stop_sending();
    idle_pct = 6;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.mismatches == 0)
      $display("gillespie_reaction_selector_core test passed");
    else
      $display("gillespie_reaction_selector_core test failed");
    $finish;
  end
endmodule
